/* rtl/sacl_pkg.sv */
// Shared types and constants of the set-associative LRU cache model.
// Used by the lookup logic and the top level; depends on nothing.
package sacl_pkg;

  localparam int ACTION_W    = 2;
  localparam int ADDR_FIELD_W = 32;
  localparam int CNT_W       = 32;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 104;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int SET_BITS_W  = 3;
  localparam int BLK_BITS_W  = 5;
  localparam int WAYS_REG_W  = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_STORE  = 2'd1,
    ACT_MODIFY = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_BITS   = 2'd0,
    REG_BLOCK_BITS = 2'd1,
    REG_WAYS       = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_LOOK   = 4'b0100,
    S_REREAD = 4'b1000
  } state_t;

  typedef struct packed {
    logic hit;
    logic evict;
  } lookup_res_t;

endpackage

/* rtl/set_assoc_cache_lru_sim_unit.sv */
// Top level of the set-associative LRU cache model: sequencer, configuration,
// saturating totals and result register. Uses sacl_pkg, sacl_ram, sacl_lookup.
//
// Each set is one row of a synchronous memory holding valid bit, tag and LRU
// rank of every way. A load or store request reads the set, then compares and
// writes the row back; a modify makes a second access that reads the set again
// after the first has written it. After reset a clearing pass writes each of
// the 2**MAX_SET_BITS rows (64 by default) once, while no request is accepted.
// A result waits in an output register and does not keep a new request from
// being accepted.
module set_assoc_cache_lru_sim_unit
  import sacl_pkg::*;
#(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // Fields from bit 0: action[1:0], address[33:2], zero fill.
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // Fields from bit 0: hit[0], evicted[1], hit_total[33:2],
  // miss_total[65:34], eviction_total[97:66], zero fill.
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW     = (ADDR_WIDTH < ADDR_FIELD_W) ? ADDR_WIDTH : ADDR_FIELD_W;
  localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int ROW_W  = MAX_WAYS * (1 + AW + RANK_W);
  localparam int DEPTH  = 1 << MAX_SET_BITS;
  localparam int SB_W   = $clog2(MAX_SET_BITS + 1);
  localparam int WC_W   = $clog2(MAX_WAYS + 1);
  localparam int SH_W   = $clog2(MAX_SET_BITS + 32);

  state_t state_r, state_nxt;

  logic [SET_BITS_W-1:0] set_bits_r;
  logic [BLK_BITS_W-1:0] blk_bits_r;
  logic [WAYS_REG_W-1:0] ways_r;

  logic [MAX_SET_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [MAX_SET_BITS-1:0] cur_set_r, cur_set_nxt;
  logic [AW-1:0]           cur_tag_r, cur_tag_nxt;
  logic                    pend_r, pend_nxt;

  logic [CNT_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic [CNT_W-1:0] miss_cnt_r, miss_cnt_nxt;
  logic [CNT_W-1:0] evt_cnt_r, evt_cnt_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [SB_W-1:0]         s_eff;
  logic [WC_W-1:0]         ways_eff;
  logic [SH_W-1:0]         tag_sh;
  logic [AW-1:0]           addr_w;
  logic [AW-1:0]           addr_sh;
  logic [MAX_SET_BITS-1:0] set_mask;
  logic [MAX_SET_BITS-1:0] in_set;
  logic [AW-1:0]           in_tag;
  logic [ACTION_W-1:0]     in_action;

  logic                    in_acc;
  logic                    can_emit;
  logic                    emit;
  logic                    ram_we;
  logic [MAX_SET_BITS-1:0] ram_waddr;
  logic [ROW_W-1:0]        ram_wdata;
  logic [MAX_SET_BITS-1:0] ram_raddr;
  logic [ROW_W-1:0]        ram_rdata;
  logic [ROW_W-1:0]        row_new;
  lookup_res_t             lk_res;

  // Effective configuration.
  always_comb begin
    if (int'(set_bits_r) > MAX_SET_BITS) begin
      s_eff = SB_W'(MAX_SET_BITS);
    end else begin
      s_eff = SB_W'(set_bits_r);
    end
    if (ways_r == '0) begin
      ways_eff = WC_W'(1);
    end else if (int'(ways_r) > MAX_WAYS) begin
      ways_eff = WC_W'(MAX_WAYS);
    end else begin
      ways_eff = WC_W'(ways_r);
    end
  end

  // Address split of the incoming request.
  assign in_action = in_tdata[ACTION_W-1:0];
  assign addr_w    = in_tdata[ACTION_W +: AW];
  assign tag_sh    = SH_W'(s_eff) + SH_W'(blk_bits_r);
  assign addr_sh   = addr_w >> blk_bits_r;
  assign set_mask  = ~({MAX_SET_BITS{1'b1}} << s_eff);
  assign in_set    = addr_sh[MAX_SET_BITS-1:0] & set_mask;
  assign in_tag    = addr_w >> tag_sh;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign can_emit  = !out_valid_r || out_tready;
  assign emit      = (state_r == S_LOOK) && can_emit;
  assign cfg_ready = 1'b1;

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (DEPTH)
  ) u_set_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sacl_lookup #(
    .MAX_WAYS (MAX_WAYS),
    .TAG_W    (AW)
  ) u_lookup (
    .row_in  (ram_rdata),
    .tag     (cur_tag_r),
    .ways    (ways_eff),
    .row_out (row_new),
    .res     (lk_res)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_set_r;
    ram_wdata = row_new;
    ram_raddr = (state_r == S_IDLE) ? in_set : cur_set_r;
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else if (emit) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    cur_set_nxt   = cur_set_r;
    cur_tag_nxt   = cur_tag_r;
    pend_nxt      = pend_r;
    hit_cnt_nxt   = hit_cnt_r;
    miss_cnt_nxt  = miss_cnt_r;
    evt_cnt_nxt   = evt_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == {MAX_SET_BITS{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          cur_set_nxt = in_set;
          cur_tag_nxt = in_tag;
          case (in_action)
            ACT_LOAD, ACT_STORE: begin
              pend_nxt  = 1'b0;
              state_nxt = S_LOOK;
            end
            ACT_MODIFY: begin
              pend_nxt  = 1'b1;
              state_nxt = S_LOOK;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_LOOK: begin
        if (can_emit) begin
          if (lk_res.hit) begin
            if (hit_cnt_r != '1) hit_cnt_nxt = hit_cnt_r + 1'b1;
          end else begin
            if (miss_cnt_r != '1) miss_cnt_nxt = miss_cnt_r + 1'b1;
          end
          if (lk_res.evict && (evt_cnt_r != '1)) begin
            evt_cnt_nxt = evt_cnt_r + 1'b1;
          end
          out_valid_nxt = 1'b1;
          out_last_nxt  = !pend_r;
          out_data_nxt  = {6'b0, evt_cnt_nxt, miss_cnt_nxt, hit_cnt_nxt,
                           lk_res.evict, lk_res.hit};
          pend_nxt      = 1'b0;
          state_nxt     = pend_r ? S_REREAD : S_IDLE;
        end
      end
      S_REREAD: begin
        state_nxt = S_LOOK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      pend_r      <= 1'b0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evt_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      set_bits_r  <= SET_BITS_W'(1);
      blk_bits_r  <= BLK_BITS_W'(1);
      ways_r      <= WAYS_REG_W'(1);
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pend_r      <= pend_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      evt_cnt_r   <= evt_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SET_BITS:   set_bits_r <= cfg_data[SET_BITS_W-1:0];
          REG_BLOCK_BITS: blk_bits_r <= cfg_data[BLK_BITS_W-1:0];
          REG_WAYS:       ways_r     <= cfg_data[WAYS_REG_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_set_r  <= cur_set_nxt;
    cur_tag_r  <= cur_tag_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_rose_after_look: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_LOOK))
    else $error("result appeared without a set lookup");

  a_first_half_rereads: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && pend_r) |=> (state_r == S_REREAD))
    else $error("first access of a modify did not reread the set");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == S_LOOK) || (state_r == S_CLEAR)))
    else $error("set memory written outside lookup or clearing pass");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[0] && out_data_r[1]))
    else $error("result flags both hit and eviction");
`endif

endmodule

/* rtl/sacl_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; instantiated for the set memory of the cache.
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/sacl_lookup.sv */
// Tag compare, victim choice and LRU rank update for one cache set row.
// Depends on sacl_pkg for the lookup result type.
module sacl_lookup
  import sacl_pkg::*;
#(
  parameter int MAX_WAYS = 8,
  parameter int TAG_W    = 32
) (
  input  logic [MAX_WAYS*(1+TAG_W+((MAX_WAYS>1)?$clog2(MAX_WAYS):1))-1:0] row_in,
  input  logic [TAG_W-1:0]                                                 tag,
  input  logic [$clog2(MAX_WAYS+1)-1:0]                                    ways,
  output logic [MAX_WAYS*(1+TAG_W+((MAX_WAYS>1)?$clog2(MAX_WAYS):1))-1:0] row_out,
  output lookup_res_t                                                      res
);

  localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WC_W   = $clog2(MAX_WAYS + 1);
  localparam int E_W    = 1 + TAG_W + RANK_W;
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

  logic              vld [MAX_WAYS];
  logic [TAG_W-1:0]  tg  [MAX_WAYS];
  logic [RANK_W-1:0] rk  [MAX_WAYS];
  logic              in_use [MAX_WAYS];
  logic              nv  [MAX_WAYS];
  logic [TAG_W-1:0]  nt  [MAX_WAYS];
  logic [RANK_W-1:0] nr  [MAX_WAYS];

  logic              hit_any;
  logic              inv_any;
  logic [RANK_W-1:0] hit_w;
  logic [RANK_W-1:0] inv_w;
  logic [RANK_W-1:0] vic_w;
  logic [RANK_W-1:0] best;
  logic [RANK_W-1:0] sel_w;
  logic [RANK_W-1:0] old_rank;
  logic              was_valid;

  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      vld[j]    = row_in[j*E_W + TAG_W + RANK_W];
      tg[j]     = row_in[j*E_W + RANK_W +: TAG_W];
      rk[j]     = row_in[j*E_W +: RANK_W];
      in_use[j] = (WC_W'(j) < ways);
    end
  end

  always_comb begin
    hit_any = 1'b0;
    hit_w   = '0;
    inv_any = 1'b0;
    inv_w   = '0;
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (!hit_any && in_use[j] && vld[j] && (tg[j] == tag)) begin
        hit_any = 1'b1;
        hit_w   = RANK_W'(j);
      end
      if (!inv_any && in_use[j] && !vld[j]) begin
        inv_any = 1'b1;
        inv_w   = RANK_W'(j);
      end
    end
  end

  always_comb begin
    best  = rk[0];
    vic_w = '0;
    for (int j = 1; j < MAX_WAYS; j++) begin
      if (in_use[j] && (rk[j] > best)) begin
        best  = rk[j];
        vic_w = RANK_W'(j);
      end
    end
  end

  always_comb begin
    if (hit_any) begin
      sel_w = hit_w;
    end else if (inv_any) begin
      sel_w = inv_w;
    end else begin
      sel_w = vic_w;
    end
    was_valid = hit_any || !inv_any;
    old_rank  = rk[sel_w];
  end

  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      nv[j] = vld[j];
      nt[j] = tg[j];
      nr[j] = rk[j];
      if ((RANK_W'(j) != sel_w) && in_use[j] && vld[j] &&
          (!was_valid || (rk[j] < old_rank)) && (rk[j] < RANK_MAX)) begin
        nr[j] = rk[j] + 1'b1;
      end
    end
    nv[sel_w] = 1'b1;
    nt[sel_w] = tag;
    nr[sel_w] = '0;
  end

  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      row_out[j*E_W +: E_W] = {nv[j], nt[j], nr[j]};
    end
  end

  assign res.hit   = hit_any;
  assign res.evict = !hit_any && !inv_any;

endmodule
